// File: rtl/lmp_pkg.sv
`default_nettype none
package lmp_pkg;

	localparam int LAYERS_DEFAULT = 256;
	localparam int LAYER_W        = 8;
	localparam int TOTAL_W        = 9;
	localparam int MEMBER_W       = 8;
	localparam int GEN_W          = 32;

	localparam logic [1:0] MODE_FIRST    = 2'd0;
	localparam logic [1:0] MODE_SEQ      = 2'd1;
	localparam logic [1:0] MODE_RANDOM   = 2'd2;
	localparam logic [1:0] MODE_RAND_SEQ = 2'd3;

	localparam logic FUNC_PICK  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef struct packed {
		logic [MEMBER_W-1:0] cursor;
		logic [MEMBER_W-1:0] anchor;
		logic                cycling;
	} entry_t;

endpackage
`default_nettype wire

// File: rtl/layered_member_picker_top.sv
// channel | direction | handshake             | beat
// in      | in        | in_valid / in_stall   | func, layer, member_total, pick_mode
// out     | out       | out_valid / out_stall | member_index, no_pick
// cfg     | in        | cfg_valid / cfg_ready | rng_seed
//
// One request at a time: the layer table read is registered, and the next
// request waits until this one's write-back is done.
// A result is registered; a new request is taken while it waits on out_stall.
// Reset clears the valid bits, the generator and the handshake state at once;
// no clearing pass.
// cfg_ready is always high.
`default_nettype none
module layered_member_picker_top #(
	parameter int LAYERS = lmp_pkg::LAYERS_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         func,
	input  wire logic [lmp_pkg::LAYER_W-1:0]  layer,
	input  wire logic [lmp_pkg::TOTAL_W-1:0]  member_total,
	input  wire logic [1:0]                   pick_mode,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [lmp_pkg::MEMBER_W-1:0]      member_index,
	output logic                              no_pick,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [lmp_pkg::GEN_W-1:0]    rng_seed
);
	import lmp_pkg::*;

	localparam int KEYS  = 2 ** LAYER_W;
	localparam int DEPTH = (LAYERS < KEYS) ? LAYERS : KEYS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [AW-1:0] slot_lut [KEYS];
	for (genvar i = 0; i < KEYS; i++) begin : g_slot
		assign slot_lut[i] = AW'(i % LAYERS);
	end

	entry_t mem [DEPTH];
	entry_t rd_q;
	logic [DEPTH-1:0] valid_q;
	logic [GEN_W-1:0] gen_q;

	logic                s1_valid_q;
	logic                func_s1;
	logic [AW-1:0]       slot_s1;
	logic [TOTAL_W-1:0]  total_s1;
	logic [1:0]          mode_s1;

	logic                out_valid_q;
	logic [MEMBER_W-1:0] member_index_q;
	logic                no_pick_q;

	logic accept, done;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = s1_valid_q;
	assign done      = s1_valid_q && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// request evaluation
	logic [TOTAL_W-1:0]  cnt;
	logic                zero;
	entry_t              cur_e, wr_e;
	logic [GEN_W-1:0]    sum, gen_nxt;
	logic [16:0]         prod;
	logic [MEMBER_W-1:0] draw, cur, nxt, pick;
	logic [TOTAL_W-1:0]  inc;
	logic                use_gen, wr_en;

	always_comb begin
		cnt     = (total_s1 > TOTAL_W'(256)) ? TOTAL_W'(256) : total_s1;
		zero    = (total_s1 == '0);
		cur_e   = valid_q[slot_s1] ? rd_q : '0;
		sum     = gen_q + {gen_q[GEN_W-12:0], gen_q[GEN_W-1:GEN_W-11]};
		gen_nxt = {sum[GEN_W-4:0], sum[GEN_W-1:GEN_W-3]};
		prod    = 17'(cnt) * 17'(gen_nxt[7:0]);
		draw    = prod[15:8];
		cur     = ({1'b0, cur_e.cursor} >= cnt) ? '0 : cur_e.cursor;
		inc     = {1'b0, cur} + TOTAL_W'(1);
		nxt     = (inc >= cnt) ? '0 : inc[MEMBER_W-1:0];
		wr_e    = cur_e;
		use_gen = 1'b0;
		wr_en   = 1'b0;
		pick    = '0;
		if (func_s1 == FUNC_PICK && !zero) begin
			unique case (mode_s1)
				MODE_FIRST: pick = '0;
				MODE_RANDOM: begin
					pick    = draw;
					use_gen = 1'b1;
				end
				MODE_SEQ, MODE_RAND_SEQ: begin
					wr_en = 1'b1;
					if (mode_s1 == MODE_RAND_SEQ && !cur_e.cycling) begin
						pick         = draw;
						use_gen      = 1'b1;
						wr_e.anchor  = draw;
						wr_e.cursor  = draw;
						wr_e.cycling = 1'b1;
					end else begin
						pick        = cur;
						wr_e.cursor = nxt;
						if (mode_s1 == MODE_RAND_SEQ && nxt == cur_e.anchor)
							wr_e.cycling = 1'b0;
					end
				end
				default: pick = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= mem[slot_lut[layer]];
		if (done && wr_en)
			mem[slot_s1] <= wr_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			gen_q       <= '0;
		end else begin
			if (accept)
				s1_valid_q <= 1'b1;
			else if (done)
				s1_valid_q <= 1'b0;
			if (done)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				gen_q <= rng_seed;
			else if (done && use_gen)
				gen_q <= gen_nxt;
			if (done && func_s1 == FUNC_CLEAR)
				valid_q <= '0;
			else if (done && wr_en)
				valid_q[slot_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			slot_s1  <= slot_lut[layer];
			total_s1 <= member_total;
			mode_s1  <= pick_mode;
		end
		if (done) begin
			member_index_q <= pick;
			no_pick_q      <= (func_s1 == FUNC_CLEAR) || zero;
		end
	end

	assign out_valid    = out_valid_q;
	assign member_index = member_index_q;
	assign no_pick      = no_pick_q;

endmodule
`default_nettype wire

// File: rtl/lmp_checker.sv
`default_nettype none
module lmp_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [lmp_pkg::MEMBER_W-1:0] member_index,
	input wire logic                         no_pick
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(member_index) && $stable(no_pick))
		else $error("stalled result changed");

	a_no_pick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_pick |-> member_index == '0)
		else $error("no_pick with nonzero index");

	// one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken during table access");

	a_result_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without pending request");

endmodule

bind layered_member_picker_top lmp_checker u_lmp_checker (.*);
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lmp_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_BEATS  = 125;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [MEMBER_W-1:0] idx;
		logic                np;
	} pick_result_t;

	typedef struct {
		logic                f;
		logic [LAYER_W-1:0]  l;
		logic [TOTAL_W-1:0]  t;
		logic [1:0]          m;
		bit                  typed;
		logic [MEMBER_W-1:0] idx;
		logic                np;
	} beat_row_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                func         = FUNC_PICK;
	logic [LAYER_W-1:0]  layer        = '0;
	logic [TOTAL_W-1:0]  member_total = '0;
	logic [1:0]          pick_mode    = MODE_FIRST;
	logic                out_stall    = 1'b0;
	logic                cfg_valid    = 1'b0;
	logic [GEN_W-1:0]    rng_seed     = '0;
	logic                in_stall;
	logic                out_valid;
	logic [MEMBER_W-1:0] member_index;
	logic                no_pick;
	logic                cfg_ready;

	// predicted block state
	logic [GEN_W-1:0]    gen_state = '0;
	logic [MEMBER_W-1:0] cur_tab [LAYERS_DEFAULT];
	logic [MEMBER_W-1:0] anc_tab [LAYERS_DEFAULT];
	logic                cyc_tab [LAYERS_DEFAULT];
	bit                  vld_tab [LAYERS_DEFAULT] = '{default: 1'b0};

	pick_result_t expected_picks[$];
	int  mismatches  = 0;
	int  beats_sent  = 0;
	int  beats_seen  = 0;
	int  cycle_count = 0;
	bit  tx_gaps     = 1'b1;
	bit  rx_gaps     = 1'b1;
	bit  hold_req    = 1'b0;

	beat_row_t directed_beats [24] = '{
		'{FUNC_PICK,  8'd0,   9'd1,   MODE_FIRST,    1'b1, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd0,   9'd0,   MODE_SEQ,      1'b1, 8'd0, 1'b1},
		'{FUNC_CLEAR, 8'd0,   9'd0,   MODE_FIRST,    1'b1, 8'd0, 1'b1},
		'{FUNC_CLEAR, 8'd255, 9'd511, MODE_RAND_SEQ, 1'b1, 8'd0, 1'b1},
		'{FUNC_PICK,  8'd255, 9'd256, MODE_FIRST,    1'b1, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd255, 9'd511, MODE_SEQ,      1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd255, 9'd511, MODE_SEQ,      1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd7,   9'd3,   MODE_SEQ,      1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd7,   9'd3,   MODE_SEQ,      1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd7,   9'd3,   MODE_SEQ,      1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd7,   9'd3,   MODE_SEQ,      1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd7,   9'd2,   MODE_SEQ,      1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd7,   9'd1,   MODE_SEQ,      1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd9,   9'd256, MODE_RANDOM,   1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd9,   9'd1,   MODE_RANDOM,   1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd3,   9'd3,   MODE_RAND_SEQ, 1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd3,   9'd3,   MODE_RAND_SEQ, 1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd3,   9'd3,   MODE_RAND_SEQ, 1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd3,   9'd3,   MODE_RAND_SEQ, 1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd0,   9'd0,   MODE_RANDOM,   1'b1, 8'd0, 1'b1},
		'{FUNC_CLEAR, 8'd3,   9'd3,   MODE_SEQ,      1'b1, 8'd0, 1'b1},
		'{FUNC_PICK,  8'd7,   9'd3,   MODE_SEQ,      1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd170, 9'd85,  MODE_RAND_SEQ, 1'b0, 8'd0, 1'b0},
		'{FUNC_PICK,  8'd85,  9'd170, MODE_SEQ,      1'b0, 8'd0, 1'b0}
	};

	layered_member_picker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.layer        (layer),
		.member_total (member_total),
		.pick_mode    (pick_mode),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.member_index (member_index),
		.no_pick      (no_pick),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.rng_seed     (rng_seed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [GEN_W-1:0] rotl32(input logic [GEN_W-1:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [MEMBER_W-1:0] draw_scaled(input logic [TOTAL_W-1:0] count);
		logic [16:0] prod;
		gen_state = rotl32(gen_state + rotl32(gen_state, 11), 3);
		prod = count * gen_state[7:0];
		return prod[15:8];
	endfunction

	function automatic pick_result_t predict_pick(input logic f, input logic [LAYER_W-1:0] l,
			input logic [TOTAL_W-1:0] t, input logic [1:0] m);
		pick_result_t        r;
		logic [TOTAL_W-1:0]  cnt;
		logic [TOTAL_W-1:0]  nxt;
		logic [MEMBER_W-1:0] a;
		r.idx = '0;
		r.np = 1'b1;
		if (f == FUNC_CLEAR) begin
			foreach (vld_tab[i])
				vld_tab[i] = 1'b0;
			return r;
		end
		if (t == '0)
			return r;
		cnt = (t > 9'd256) ? 9'd256 : t;
		r.np = 1'b0;
		case (m)
			MODE_FIRST: begin
				r.idx = '0;
			end
			MODE_RANDOM: begin
				r.idx = draw_scaled(cnt);
			end
			default: begin
				if (!vld_tab[l]) begin
					cur_tab[l] = '0;
					anc_tab[l] = '0;
					cyc_tab[l] = 1'b0;
					vld_tab[l] = 1'b1;
				end
				if (m == MODE_RAND_SEQ && !cyc_tab[l]) begin
					a = draw_scaled(cnt);
					if ({1'b0, a} >= cnt)
						a = MEMBER_W'(cnt - 9'd1);
					cur_tab[l] = a;
					anc_tab[l] = a;
					cyc_tab[l] = 1'b1;
					r.idx = a;
				end else begin
					if ({1'b0, cur_tab[l]} >= cnt)
						cur_tab[l] = '0;
					r.idx = cur_tab[l];
					nxt = {1'b0, cur_tab[l]} + 9'd1;
					cur_tab[l] = (nxt >= cnt) ? 8'd0 : nxt[7:0];
					if (m == MODE_RAND_SEQ && cur_tab[l] == anc_tab[l])
						cyc_tab[l] = 1'b0;
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [TOTAL_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return TOTAL_W'($urandom_range(1, 8));
		else if (r < 17)
			return TOTAL_W'($urandom_range(1, 256));
		else if (r < 19)
			return TOTAL_W'($urandom_range(257, 511));
		return '0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d want %0d", beats_seen, what, got, want);
		mismatches++;
	endtask

	// caller stands at a rising edge; returns at the edge that took the beat, or after a random idle gap behind it
	task automatic send_beat(input logic f, input logic [LAYER_W-1:0] l,
			input logic [TOTAL_W-1:0] t, input logic [1:0] m,
			input bit typed, input logic [MEMBER_W-1:0] t_idx, input logic t_np);
		pick_result_t want;
		in_valid     <= 1'b1;
		func         <= f;
		layer        <= l;
		member_total <= t;
		pick_mode    <= m;
		do
			@(posedge clk);
		while (in_stall);
		want = predict_pick(f, l, t, m);
		if (typed) begin
			want.idx = t_idx;
			want.np = t_np;
		end
		expected_picks.push_back(want);
		beats_sent++;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	initial begin
		pick_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
				if (expected_picks.size() == 0) begin
					report_mismatch("unexpected result, member_index", member_index, 0);
				end else begin
					got = expected_picks.pop_front();
					if (member_index !== got.idx)
						report_mismatch("member_index", member_index, got.idx);
					if (no_pick !== got.np)
						report_mismatch("no_pick", no_pick, got.np);
				end
				beats_seen++;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [GEN_W-1:0]   seed_plan [4];
		logic [LAYER_W-1:0] lay;
		logic [TOTAL_W-1:0] cnt;
		logic [TOTAL_W-1:0] t;
		logic [1:0]         mode;
		int                 kind;
		int                 len;
		int                 phase_start;
		seed_plan[0] = 32'hFFFF_FFFF;
		seed_plan[1] = $urandom;
		seed_plan[2] = $urandom;
		seed_plan[3] = 32'h0000_0000;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// generator still at its reset value of zero here
		foreach (directed_beats[i])
			send_beat(directed_beats[i].f, directed_beats[i].l, directed_beats[i].t,
				directed_beats[i].m, directed_beats[i].typed, directed_beats[i].idx,
				directed_beats[i].np);

		for (int ph = 0; ph < 4; ph++) begin
			in_valid <= 1'b0;
			while (expected_picks.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			cfg_valid <= 1'b1;
			rng_seed  <= seed_plan[ph];
			do
				@(posedge clk);
			while (!cfg_ready);
			cfg_valid <= 1'b0;
			gen_state = seed_plan[ph];
			tx_gaps = (ph != 3);
			rx_gaps = (ph != 3);

			if (ph == 1) begin
				// output held off while input keeps coming, fills the pipe
				hold_req = 1'b1;
				for (int k = 0; k < 24; k++)
					send_beat(FUNC_PICK, 8'd40, 9'd5, (k % 2) ? MODE_SEQ : MODE_RAND_SEQ,
						1'b0, 8'd0, 1'b0);
			end

			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					lay = ($urandom_range(0, 1) != 0) ? LAYER_W'($urandom_range(0, 7))
						: LAYER_W'($urandom_range(0, 255));
					cnt = pick_count();
					if (cnt == '0)
						cnt = 9'd1;
					mode = ($urandom_range(0, 1) != 0) ? MODE_RAND_SEQ : MODE_SEQ;
					len = $urandom_range(1, (cnt > 9'd11) ? 24 : 2 * cnt + 2);
					for (int j = 0; j < len; j++) begin
						t = ($urandom_range(0, 7) == 0) ? TOTAL_W'($urandom_range(1, cnt))
							: cnt;
						send_beat(FUNC_PICK, lay, t, mode, 1'b0, 8'd0, 1'b0);
					end
				end else if (kind == 7) begin
					send_beat(FUNC_PICK, LAYER_W'($urandom_range(0, 255)), pick_count(),
						MODE_RANDOM, 1'b0, 8'd0, 1'b0);
				end else if (kind == 8) begin
					send_beat(($urandom_range(0, 7) == 0) ? FUNC_CLEAR : FUNC_PICK,
						LAYER_W'($urandom_range(0, 255)), TOTAL_W'($urandom_range(0, 511)),
						2'($urandom_range(0, 3)), 1'b0, 8'd0, 1'b0);
				end else begin
					case ($urandom_range(0, 2))
						0: send_beat(FUNC_CLEAR, LAYER_W'($urandom_range(0, 255)),
							TOTAL_W'($urandom_range(0, 511)), 2'($urandom_range(0, 3)),
							1'b0, 8'd0, 1'b0);
						1: send_beat(FUNC_PICK, LAYER_W'($urandom_range(0, 255)), 9'd0,
							2'($urandom_range(0, 3)), 1'b0, 8'd0, 1'b0);
						default: send_beat(FUNC_PICK, LAYER_W'($urandom_range(0, 255)),
							pick_count(), MODE_FIRST, 1'b0, 8'd0, 1'b0);
					endcase
				end
			end
		end

		in_valid <= 1'b0;
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_picks.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
